### rtl/core/krss_pkg.sv
package krss_pkg;

  localparam int MODE_W = 2;
  localparam int KEY_W = 32;
  localparam int TAG_W = 32;
  localparam int STATUS_W = 2;
  localparam int REC_W = KEY_W + TAG_W;
  localparam int DEFAULT_STACK_DEPTH = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_SORT   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic load_item;
    logic srch_start;
    logic sort_start;
    logic rd_i;
    logic rd_j;
    logic load_rec;
    logic srch_hit;
    logic step_j;
    logic swap;
    logic wr_i;
    logic finish;
  } cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic  in_valid;
    mode_t mode;
    logic  occ_zero;
    logic  occ_le1;
    logic  key_eq;
    logic  key_gt;
    logic  j_zero;
    logic  i_one;
    logic  slot_free;
  } stat_t;

endpackage

### rtl/core/krss_in_if.sv
interface krss_in_if;
  logic                             valid;
  logic                             ready;
  logic [krss_pkg::MODE_W-1:0]      mode;
  logic signed [krss_pkg::KEY_W-1:0] key;
  logic [krss_pkg::TAG_W-1:0]       name_tag;

  modport source (output valid, mode, key, name_tag, input ready);
  modport sink (input valid, mode, key, name_tag, output ready);
endinterface

### rtl/core/krss_out_if.sv
interface krss_out_if;
  logic                              valid;
  logic                              ready;
  logic [krss_pkg::STATUS_W-1:0]     status;
  logic signed [krss_pkg::KEY_W-1:0] found_key;
  logic [krss_pkg::TAG_W-1:0]        found_name;

  modport source (output valid, status, found_key, found_name, input ready);
  modport sink (input valid, status, found_key, found_name, output ready);
endinterface

### rtl/core/krss_ram.sv
module krss_ram #(
  parameter int WIDTH = krss_pkg::REC_W,
  parameter int DEPTH = krss_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/krss_ctrl.sv
module krss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  krss_pkg::stat_t stat,
  output krss_pkg::cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECODE   = 10'b0000000010,
    S_SRCH_RD  = 10'b0000000100,
    S_SRCH_CMP = 10'b0000001000,
    S_SORT_RDI = 10'b0000010000,
    S_SORT_LDI = 10'b0000100000,
    S_SORT_RDJ = 10'b0001000000,
    S_SORT_CMP = 10'b0010000000,
    S_SORT_WRI = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode)
          krss_pkg::MODE_SEARCH: begin
            if (stat.occ_zero) begin
              state_next = S_FIN;
            end else begin
              cmd.srch_start = 1'b1;
              state_next = S_SRCH_RD;
            end
          end
          krss_pkg::MODE_SORT: begin
            if (stat.occ_le1) begin
              state_next = S_FIN;
            end else begin
              cmd.sort_start = 1'b1;
              state_next = S_SORT_RDI;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_SRCH_RD: begin
        cmd.rd_j = 1'b1;
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat.key_eq) begin
          cmd.srch_hit = 1'b1;
          state_next = S_FIN;
        end else if (stat.j_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.step_j = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SORT_RDI: begin
        cmd.rd_i = 1'b1;
        state_next = S_SORT_LDI;
      end
      S_SORT_LDI: begin
        cmd.load_rec = 1'b1;
        state_next = S_SORT_RDJ;
      end
      S_SORT_RDJ: begin
        cmd.rd_j = 1'b1;
        state_next = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd.swap = stat.key_gt;
        if (stat.j_zero) begin
          state_next = S_SORT_WRI;
        end else begin
          cmd.step_j = 1'b1;
          state_next = S_SORT_RDJ;
        end
      end
      S_SORT_WRI: begin
        cmd.wr_i = 1'b1;
        state_next = stat.i_one ? S_FIN : S_SORT_RDI;
      end
      S_FIN: begin
        if (stat.slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/krss_dp.sv
module krss_dp #(
  parameter int STACK_DEPTH = krss_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  krss_in_if.sink         in_ch,
  krss_out_if.source      out_ch,
  input  krss_pkg::cmd_t  cmd,
  output krss_pkg::stat_t stat
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int OCC_W = $clog2(STACK_DEPTH + 1);

  logic [OCC_W-1:0]                  occ;
  logic [OCC_W-1:0]                  occ_m1;
  logic                              occ_full;
  logic                              occ_zero;
  krss_pkg::mode_t                   item_mode;
  logic signed [krss_pkg::KEY_W-1:0] item_key;
  logic [krss_pkg::TAG_W-1:0]        item_tag;
  logic [ADDR_W-1:0]                 idx_i;
  logic [ADDR_W-1:0]                 idx_j;
  logic signed [krss_pkg::KEY_W-1:0] rec_key;
  logic [krss_pkg::TAG_W-1:0]        rec_name;
  logic                              found;
  logic signed [krss_pkg::KEY_W-1:0] found_key;
  logic [krss_pkg::TAG_W-1:0]        found_name;
  logic                              out_valid;
  krss_pkg::status_t                 out_status;
  logic signed [krss_pkg::KEY_W-1:0] out_key;
  logic [krss_pkg::TAG_W-1:0]        out_name;
  krss_pkg::status_t                 res_status;
  logic [krss_pkg::REC_W-1:0]        rd_rec;
  logic signed [krss_pkg::KEY_W-1:0] rd_key;
  logic [krss_pkg::TAG_W-1:0]        rd_name;
  logic                              push_wr;
  logic                              ram_we;
  logic [ADDR_W-1:0]                 ram_waddr;
  logic [krss_pkg::REC_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]                 ram_raddr;

  assign occ_m1 = occ - OCC_W'(1);
  assign occ_full = (occ == OCC_W'(STACK_DEPTH));
  assign occ_zero = (occ == '0);
  assign rd_key = rd_rec[krss_pkg::REC_W-1:krss_pkg::TAG_W];
  assign rd_name = rd_rec[krss_pkg::TAG_W-1:0];
  assign push_wr = cmd.finish && (item_mode == krss_pkg::MODE_PUSH) && !occ_full;

  // The record store has one write port; swap, write-back and push never coincide.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx_j;
    ram_wdata = {rec_key, rec_name};
    priority if (cmd.swap) begin
      ram_we = 1'b1;
    end else if (cmd.wr_i) begin
      ram_we = 1'b1;
      ram_waddr = idx_i;
    end else if (push_wr) begin
      ram_we = 1'b1;
      ram_waddr = occ[ADDR_W-1:0];
      ram_wdata = {item_key, item_tag};
    end
  end

  assign ram_raddr = cmd.rd_i ? idx_i : idx_j;

  krss_ram #(
    .WIDTH (krss_pkg::REC_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_i || cmd.rd_j),
    .raddr (ram_raddr),
    .rdata (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode <= krss_pkg::mode_t'(in_ch.mode);
      item_key <= in_ch.key;
      item_tag <= in_ch.name_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_start) begin
      idx_i <= occ_m1[ADDR_W-1:0];
    end else if (cmd.wr_i) begin
      idx_i <= idx_i - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.srch_start) begin
      idx_j <= occ_m1[ADDR_W-1:0];
    end else if (cmd.load_rec) begin
      idx_j <= idx_i - ADDR_W'(1);
    end else if (cmd.step_j) begin
      idx_j <= idx_j - ADDR_W'(1);
    end
  end

  // The held record is the live content of position i during the inner walk.
  always_ff @(posedge clk) begin
    if (cmd.load_rec || cmd.swap) begin
      rec_key <= rd_key;
      rec_name <= rd_name;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.load_item) begin
      found <= 1'b0;
    end else if (cmd.srch_hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_hit) begin
      found_key <= rd_key;
      found_name <= rd_name;
    end
  end

  always_comb begin
    unique case (item_mode)
      krss_pkg::MODE_PUSH:   res_status = occ_full ? krss_pkg::ST_FULL : krss_pkg::ST_OK;
      krss_pkg::MODE_POP:    res_status = occ_zero ? krss_pkg::ST_EMPTY : krss_pkg::ST_OK;
      krss_pkg::MODE_SEARCH: res_status = found ? krss_pkg::ST_OK : krss_pkg::ST_NOT_FOUND;
      default:               res_status = krss_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (push_wr) begin
      occ <= occ + OCC_W'(1);
    end else if (cmd.finish && (item_mode == krss_pkg::MODE_POP) && !occ_zero) begin
      occ <= occ_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= res_status;
      out_key <= found ? found_key : '0;
      out_name <= found ? found_name : '0;
    end
  end

  assign in_ch.ready = cmd.in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.status = out_status;
  assign out_ch.found_key = out_key;
  assign out_ch.found_name = out_name;

  assign stat.in_valid = in_ch.valid;
  assign stat.mode = item_mode;
  assign stat.occ_zero = occ_zero;
  assign stat.occ_le1 = (occ <= OCC_W'(1));
  assign stat.key_eq = (rd_key == item_key);
  assign stat.key_gt = (rec_key > rd_key);
  assign stat.j_zero = (idx_j == '0);
  assign stat.i_one = (idx_i == ADDR_W'(1));
  assign stat.slot_free = !out_valid || out_ch.ready;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(STACK_DEPTH))
    else $error("occupancy above stack depth");

  a_occ_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    !cmd.finish |=> $stable(occ))
    else $error("occupancy changed outside result delivery");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.swap, cmd.wr_i, push_wr}))
    else $error("two writers on the record store");

  a_hit_key: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_hit |=> found_key == item_key)
    else $error("search hit captured a record with another key");

endmodule

### rtl/core/keyed_record_stack_search_sort.sv
// Channel   Role    Beat payload
// in_ch     sink    mode, key, name_tag
// out_ch    source  status, found_key, found_name
//
// An input beat is taken only while the sequencer is idle; one result beat follows.
// Push and pop go from decode straight to delivery; a search reads, then compares, each entry
// scanned. A sort reads and loads the record at position i, reads and compares each pair in
// its compare walk, then writes i back, all through the one-read, one-write record RAM.
// Synchronous reset empties the stack; the record RAM needs no clearing pass.
// A new item is taken while a result waits; its own result then holds until out_ch drains.
module keyed_record_stack_search_sort #(
  parameter int STACK_DEPTH = krss_pkg::DEFAULT_STACK_DEPTH
) (
  input logic        clk,
  input logic        rst,
  krss_in_if.sink    in_ch,
  krss_out_if.source out_ch
);

  krss_pkg::cmd_t  cmd;
  krss_pkg::stat_t stat;

  krss_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  krss_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule
